// File: hdl/stpc_pkg.sv
// shared types, register codes and helper functions for the trim compensation core
package stpc_pkg;

	localparam int unsigned CFG_AW = 5;
	localparam int unsigned CFG_DW = 64;

	localparam logic [1:0] REG_TEMP_TRIM    = 2'd0;
	localparam logic [1:0] REG_PRESS_TRIM_A = 2'd1;
	localparam logic [1:0] REG_PRESS_TRIM_B = 2'd2;
	localparam logic [1:0] REG_PRESS_TRIM_C = 2'd3;

	typedef struct packed {
		logic [47:0] temp_trim;
		logic [63:0] press_trim_a;
		logic [63:0] press_trim_b;
		logic [15:0] press_trim_c;
	} trim_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		T_A,
		T_D,
		T_B,
		T_O,
		P_V1,
		P_SQ,
		P_V2A,
		P_V2B,
		P_V1A,
		P_V1B,
		P_V1C,
		P_P,
		P_DST,
		P_DW,
		P_C1,
		P_C2,
		P_C3,
		P_FIN,
		S_OUT
	} state_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
		return $signed(v) >>> s;
	endfunction

endpackage

// File: hdl/stpc_if.sv
// valid/ready channel interfaces for raw samples and compensated results
interface stpc_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [19:0] raw_sample;

	modport source (output valid, output mode, output raw_sample, input ready);
	modport sink (input valid, input mode, input raw_sample, output ready);
endinterface

interface stpc_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] temperature_centi;
	logic [31:0] pressure_pa;
	logic        divide_guard;

	modport source (output valid, output kind, output temperature_centi,
		output pressure_pa, output divide_guard, input ready);
	modport sink (input valid, input kind, input temperature_centi,
		input pressure_pa, input divide_guard, output ready);
endinterface

// File: hdl/stpc_regs.sv
// trim coefficient registers behind the apb port
module stpc_regs
	import stpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output trim_t             trim
);

	trim_t      trim_q;
	logic [1:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:3];
	assign wr     = psel & penable & pwrite;
	assign trim   = trim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_TEMP_TRIM:    trim_q.temp_trim    <= pwdata[47:0];
				REG_PRESS_TRIM_A: trim_q.press_trim_a <= pwdata;
				REG_PRESS_TRIM_B: trim_q.press_trim_b <= pwdata;
				REG_PRESS_TRIM_C: trim_q.press_trim_c <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TEMP_TRIM:    prdata = {16'b0, trim_q.temp_trim};
			REG_PRESS_TRIM_A: prdata = trim_q.press_trim_a;
			REG_PRESS_TRIM_B: prdata = trim_q.press_trim_b;
			REG_PRESS_TRIM_C: prdata = {48'b0, trim_q.press_trim_c};
			default:          prdata = '0;
		endcase
	end

endmodule

// File: hdl/stpc_mul.sv
// shared 32x32 multiplier, low word of the product
module stpc_mul
	import stpc_pkg::*;
(
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p
);

	// only the low word is ever needed, so the product is kept at 32 bits
	assign p = a * b;

endmodule

// File: hdl/stpc_div.sv
// restoring unsigned 32-bit divider, one quotient bit per cycle
module stpc_div
	import stpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quotient,
	output div_stat_t   stat
);

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] sh;
	logic [33:0] diff;

	assign sh        = {rem_q, quo_q[31]};
	assign diff      = {1'b0, sh} - {2'b0, divisor};
	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			// trial subtract, keep the shifted remainder when it goes negative
			if (diff[33]) begin
				rem_q <= sh[31:0];
			end else begin
				rem_q <= diff[31:0];
			end
			quo_q <= {quo_q[30:0], ~diff[33]};
		end
	end

endmodule

// File: hdl/sensor_temp_pressure_compensation_core.sv
// top level: sequencer, working registers and result stage of the trim compensation core
//
//  channel | dir | beat fields
//  --------+-----+----------------------------------------------------
//  smp     | in  | mode, raw_sample
//  res     | out | kind, temperature_centi, pressure_pa, divide_guard
//  apb     | in  | 64-bit trim registers at byte address 8*i
//
// a temperature beat steps through T_A, T_D, T_B and T_O before its result is valid
// a pressure beat with a zero scale term skips the divider and goes from P_P straight to the result
// the pressure figure is set by the serial divider, one quotient bit at a time
// each temperature step and most pressure steps are one pass through the single shared multiplier
// smp.ready is high only while idle; a result holds in the output stage until taken
// reset clears the trim registers and the stored fine temperature to zero
module sensor_temp_pressure_compensation_core
	import stpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	stpc_in_if.sink           smp,
	stpc_out_if.source        res
);

	trim_t       trim;
	state_t      state_q, state_d;
	div_stat_t   dstat;
	logic [31:0] ma, mb, prod, quo;
	logic        div_start;

	logic        mode_q;
	logic [19:0] adc_q;
	logic [31:0] fine_q, v1_q, sq_q, t_q, u_q, v2_q, w_q, p_q;
	logic        hi_q;
	logic [31:0] temp_q, press_q;
	logic        guard_q;

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] tdiff, pterm;

	assign t1 = {16'b0, trim.temp_trim[15:0]};
	assign t2 = sx16(trim.temp_trim[31:16]);
	assign t3 = sx16(trim.temp_trim[47:32]);
	assign p1 = {16'b0, trim.press_trim_a[15:0]};
	assign p2 = sx16(trim.press_trim_a[31:16]);
	assign p3 = sx16(trim.press_trim_a[47:32]);
	assign p4 = sx16(trim.press_trim_a[63:48]);
	assign p5 = sx16(trim.press_trim_b[15:0]);
	assign p6 = sx16(trim.press_trim_b[31:16]);
	assign p7 = sx16(trim.press_trim_b[47:32]);
	assign p8 = sx16(trim.press_trim_b[63:48]);
	assign p9 = sx16(trim.press_trim_c);

	assign tdiff = {16'b0, adc_q[19:4]} - t1;
	assign pterm = (32'd1048576 - {12'b0, adc_q}) - asr(v2_q, 12);

	stpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.trim    (trim)
	);

	stpc_mul u_mul (
		.a (ma),
		.b (mb),
		.p (prod)
	);

	stpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (p_q[31] ? p_q : {p_q[30:0], 1'b0}),
		.divisor  (w_q),
		.quotient (quo),
		.stat     (dstat)
	);

	assign smp.ready             = (state_q == S_IDLE);
	assign res.valid             = (state_q == S_OUT);
	assign res.kind              = mode_q;
	assign res.temperature_centi = temp_q;
	assign res.pressure_pa       = press_q;
	assign res.divide_guard      = guard_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ma        = '0;
		mb        = '0;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (smp.valid) begin
					state_d = smp.mode ? P_V1 : T_A;
				end
			end
			T_A: begin
				ma      = {15'b0, adc_q[19:3]} - {t1[30:0], 1'b0};
				mb      = t2;
				state_d = T_D;
			end
			T_D: begin
				ma      = tdiff;
				mb      = tdiff;
				state_d = T_B;
			end
			T_B: begin
				ma      = sq_q;
				mb      = t3;
				state_d = T_O;
			end
			T_O: begin
				ma      = fine_q;
				mb      = 32'd5;
				state_d = S_OUT;
			end
			P_V1: state_d = P_SQ;
			P_SQ: begin
				ma      = asr(v1_q, 2);
				mb      = asr(v1_q, 2);
				state_d = P_V2A;
			end
			P_V2A: begin
				ma      = asr(sq_q, 11);
				mb      = p6;
				state_d = P_V2B;
			end
			P_V2B: begin
				ma      = v1_q;
				mb      = p5;
				state_d = P_V1A;
			end
			P_V1A: begin
				ma      = p3;
				mb      = asr(sq_q, 13);
				state_d = P_V1B;
			end
			P_V1B: begin
				ma      = p2;
				mb      = v1_q;
				state_d = P_V1C;
			end
			P_V1C: begin
				ma      = 32'd32768 + u_q;
				mb      = p1;
				state_d = P_P;
			end
			P_P: begin
				ma      = pterm;
				mb      = 32'd3125;
				// zero scale term short-cuts straight to a guarded result
				state_d = (w_q == '0) ? S_OUT : P_DST;
			end
			P_DST: begin
				div_start = 1'b1;
				state_d   = P_DW;
			end
			P_DW: begin
				if (dstat.done) begin
					state_d = P_C1;
				end
			end
			P_C1: begin
				ma      = {3'b0, p_q[31:3]};
				mb      = {3'b0, p_q[31:3]};
				state_d = P_C2;
			end
			P_C2: begin
				ma      = p9;
				mb      = t_q;
				state_d = P_C3;
			end
			P_C3: begin
				ma      = {2'b0, p_q[31:2]};
				mb      = p8;
				state_d = P_FIN;
			end
			P_FIN: state_d = S_OUT;
			S_OUT: begin
				if (res.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q <= '0;
		end else if (state_q == T_B) begin
			fine_q <= t_q + asr(prod, 14);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (smp.valid) begin
					mode_q <= smp.mode;
					adc_q  <= smp.raw_sample;
				end
			end
			T_A: t_q  <= asr(prod, 11);
			T_D: sq_q <= asr(prod, 12);
			T_O: begin
				temp_q  <= asr(prod + 32'd128, 8);
				press_q <= '0;
				guard_q <= 1'b0;
			end
			P_V1:  v1_q <= asr(fine_q, 1) - 32'd64000;
			P_SQ:  sq_q <= prod;
			P_V2A: t_q  <= prod;
			P_V2B: v2_q <= asr(t_q + {prod[30:0], 1'b0}, 2) + {p4[15:0], 16'b0};
			P_V1A: t_q  <= asr(prod, 3);
			P_V1B: u_q  <= asr(t_q + asr(prod, 1), 18);
			P_V1C: w_q  <= asr(prod, 15);
			P_P: begin
				p_q     <= prod;
				temp_q  <= '0;
				press_q <= '0;
				guard_q <= (w_q == '0);
			end
			P_DST: hi_q <= p_q[31];
			P_DW: begin
				if (dstat.done) begin
					p_q <= hi_q ? {quo[30:0], 1'b0} : quo;
				end
			end
			P_C1:  t_q  <= {13'b0, prod[31:13]};
			P_C2:  u_q  <= asr(prod, 12);
			P_C3:  v2_q <= asr(prod, 13);
			P_FIN: press_q <= p_q + asr(u_q + v2_q + p7, 4);
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_div_busy_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.busy |-> (state_q == P_DW))
		else $error("divider running outside its wait step");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> (state_q == P_DW))
		else $error("divider finished outside its wait step");

	a_guard_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.divide_guard) |-> (res.kind && res.pressure_pa == '0))
		else $error("guarded beat is not a zero pressure result");

	a_fine_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != T_B) |=> (fine_q == $past(fine_q)))
		else $error("fine temperature changed outside the temperature path");
`endif

endmodule

// File: verif/stpc_checker.sv
// checker: watches the sample and result channels, predicts results and compares them
module stpc_checker
	import stpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        smp_valid,
	input  logic        smp_ready,
	input  logic        smp_mode,
	input  logic [19:0] smp_raw,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic        res_kind,
	input  logic [31:0] res_temp,
	input  logic [31:0] res_press,
	input  logic        res_guard,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        kind;
		logic [31:0] temp;
		logic [31:0] press;
		logic        guard;
	} comp_result_t;

	comp_result_t awaited_q[$];
	logic [47:0] t_trim;
	logic [63:0] p_trim_a;
	logic [63:0] p_trim_b;
	logic [15:0] p_trim_c;
	logic [31:0] t_fine;

	function automatic logic [31:0] sext(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sra(input logic [31:0] v, input int s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] prod;
		prod = {32'd0, a} * {32'd0, b};
		return prod[31:0];
	endfunction

	task automatic compensate(input logic mode, input logic [19:0] raw);
		comp_result_t r;
		logic [31:0] adc, t1, t2, t3, a, b, d, v1, v2, q, sq, p, p1, pdiv;
		adc = {12'd0, raw};
		r = '0;
		r.kind = mode;
		if (!mode) begin
			t1 = {16'd0, t_trim[15:0]};
			t2 = sext(t_trim[31:16]);
			t3 = sext(t_trim[47:32]);
			a = sra(mul32((adc >> 3) - (t1 << 1), t2), 11);
			d = (adc >> 4) - t1;
			b = sra(mul32(sra(mul32(d, d), 12), t3), 14);
			t_fine = a + b;
			r.temp = sra(mul32(t_fine, 32'd5) + 32'd128, 8);
		end else begin
			p1 = {16'd0, p_trim_a[15:0]};
			v1 = sra(t_fine, 1) - 32'd64000;
			q = sra(v1, 2);
			sq = mul32(q, q);
			v2 = mul32(sra(sq, 11), sext(p_trim_b[31:16]));
			v2 = v2 + (mul32(v1, sext(p_trim_b[15:0])) << 1);
			v2 = sra(v2, 2) + (sext(p_trim_a[63:48]) << 16);
			v1 = sra(sra(mul32(sext(p_trim_a[47:32]), sra(sq, 13)), 3)
				+ sra(mul32(sext(p_trim_a[31:16]), v1), 1), 18);
			pdiv = sra(mul32(32'd32768 + v1, p1), 15);
			if (pdiv == 0) begin
				r.guard = 1'b1;
			end else begin
				p = mul32((32'd1048576 - adc) - sra(v2, 12), 32'd3125);
				if (p < 32'h80000000) p = (p << 1) / pdiv;
				else p = (p / pdiv) << 1;
				v1 = sra(mul32(sext(p_trim_c), mul32(p >> 3, p >> 3) >> 13), 12);
				v2 = sra(mul32(p >> 2, sext(p_trim_b[63:48])), 13);
				r.press = p + sra(v1 + v2 + sext(p_trim_b[47:32]), 4);
			end
		end
		awaited_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		comp_result_t e;
		if (!arst_n) begin
			t_trim = '0;
			p_trim_a = '0;
			p_trim_b = '0;
			p_trim_c = '0;
			t_fine = '0;
			fail_count = 0;
			awaited_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[4:3])
					REG_TEMP_TRIM: t_trim = pwdata[47:0];
					REG_PRESS_TRIM_A: p_trim_a = pwdata;
					REG_PRESS_TRIM_B: p_trim_b = pwdata;
					REG_PRESS_TRIM_C: p_trim_c = pwdata[15:0];
					default: ;
				endcase
			end
			if (res_valid && res_ready) begin
				if (awaited_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result beat kind=%0d", res_kind);
				end else begin
					e = awaited_q.pop_front();
					if (e.kind !== res_kind || e.temp !== res_temp || e.press !== res_press
						|| e.guard !== res_guard) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch exp k=%0d t=%0d p=%0d g=%0d got k=%0d t=%0d p=%0d g=%0d",
								e.kind, $signed(e.temp), e.press, e.guard, res_kind,
								$signed(res_temp), res_press, res_guard);
					end
				end
			end
			if (smp_valid && smp_ready) compensate(smp_mode, smp_raw);
			pending = awaited_q.size();
		end
	end
endmodule

// File: verif/tb_sensor_temp_pressure_compensation_core.sv
// top: drives trim writes, samples and result stalls, and reports the verdict
module tb_sensor_temp_pressure_compensation_core;
	import stpc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	int          idle_pct;
	int          stall_pct;

	stpc_in_if  smp ();
	stpc_out_if res ();

	sensor_temp_pressure_compensation_core dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.smp(smp.sink), .res(res.source)
	);

	stpc_checker chk (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata),
		.smp_valid(smp.valid), .smp_ready(smp.ready), .smp_mode(smp.mode),
		.smp_raw(smp.raw_sample),
		.res_valid(res.valid), .res_ready(res.ready), .res_kind(res.kind),
		.res_temp(res.temperature_centi), .res_press(res.pressure_pa),
		.res_guard(res.divide_guard), .fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// receiver stalls
	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic write_trim(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'd0};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// valid drops at the falling edge after the beat, and the next beat waits for a later falling edge and any idle time
	task automatic send_sample(input logic mode, input logic [19:0] raw);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) @(negedge clk);
		smp.valid <= 1'b1;
		smp.mode <= mode;
		smp.raw_sample <= raw;
		@(posedge clk);
		while (!smp.ready) @(posedge clk);
		@(negedge clk);
		smp.valid <= 1'b0;
	endtask

	task automatic drain;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// style 0 gives trims near typical sensor values with random jitter in the low bits, else fully random trims
	task automatic load_trims(input int style);
		logic [63:0] a, b;
		if (style == 0) begin
			write_trim(REG_TEMP_TRIM, {16'd0, 16'(50 + $urandom_range(15)),
				16'd26000 + 16'($urandom_range(2000)), 16'd27000 + 16'($urandom_range(2000))});
			a = {16'd7000 + 16'($urandom_range(2000)), 16'd3024 + 16'($urandom_range(100)),
				-16'sd10600 + 16'($urandom_range(500)), 16'd36000 + 16'($urandom_range(3000))};
			b = {-16'sd12000 + 16'($urandom_range(500)), 16'd15500 + 16'($urandom_range(100)),
				-16'sd7 + 16'($urandom_range(14)), 16'd150 + 16'($urandom_range(100))};
			write_trim(REG_PRESS_TRIM_A, a);
			write_trim(REG_PRESS_TRIM_B, b);
			write_trim(REG_PRESS_TRIM_C, {48'd0, 16'd4000 + 16'($urandom_range(1000))});
		end else begin
			write_trim(REG_TEMP_TRIM, {$urandom, $urandom});
			write_trim(REG_PRESS_TRIM_A, {$urandom, $urandom});
			write_trim(REG_PRESS_TRIM_B, {$urandom, $urandom});
			write_trim(REG_PRESS_TRIM_C, {$urandom, $urandom});
		end
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp.valid = 1'b0;
		smp.mode = 1'b0;
		smp.raw_sample = '0;
		res.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// zero trims: pressure before any temperature, zero divisor
		send_sample(1'b1, 20'h80000);
		send_sample(1'b0, 20'h00000);
		send_sample(1'b1, 20'hFFFFF);
		drain();
		// all-ones and extreme trims
		write_trim(REG_TEMP_TRIM, 64'h0000_FFFF_FFFF_FFFF);
		write_trim(REG_PRESS_TRIM_A, 64'hFFFF_FFFF_FFFF_FFFF);
		write_trim(REG_PRESS_TRIM_B, 64'hFFFF_FFFF_FFFF_FFFF);
		write_trim(REG_PRESS_TRIM_C, 64'h0000_0000_0000_FFFF);
		send_sample(1'b0, 20'hFFFFF);
		send_sample(1'b1, 20'h00000);
		send_sample(1'b1, 20'hFFFFF);
		drain();
		write_trim(REG_TEMP_TRIM, 64'h0000_8000_7FFF_FFFF);
		write_trim(REG_PRESS_TRIM_A, 64'h7FFF_8000_7FFF_FFFF);
		write_trim(REG_PRESS_TRIM_B, 64'h8000_7FFF_8000_7FFF);
		write_trim(REG_PRESS_TRIM_C, 64'h0000_0000_0000_8000);
		send_sample(1'b0, 20'h55555);
		send_sample(1'b1, 20'hAAAAA);
		send_sample(1'b0, 20'hAAAAA);
		send_sample(1'b1, 20'h55555);
		drain();
		load_trims(0);
		for (k = 0; k < 8; k++) send_sample(k[0], 20'h60000 + 20'($urandom_range(65535)));
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 85; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 85; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			load_trims(phase == 5 ? 1 : 0);
			for (k = 0; k < 80; k++) begin
				if ($urandom_range(9) < 8)
					send_sample(k[0] ^ ($urandom_range(9) == 0),
						20'h50000 + 20'($urandom_range(20'h40000)));
				else
					send_sample(1'($urandom_range(1)), 20'($urandom));
				if (k == 40 && phase == 3) while (pending != 0) @(negedge clk);
			end
			drain();
		end
		stall_pct = 0;
		drain();
		if (fail_count == 0) $display("tb_sensor_temp_pressure_compensation_core OK");
		else $display("tb_sensor_temp_pressure_compensation_core NOT OK");
		$finish;
	end

	initial begin
		#4ms;
		$display("tb_sensor_temp_pressure_compensation_core NOT OK");
		$finish;
	end
endmodule
